FILE: rtl/wvl_pkg.sv
// shared types, register codes, constants and saturation helper of the wall velocity limiter
package wvl_pkg;

    typedef struct packed {
        logic signed [15:0] x_min_line;
        logic signed [15:0] x_max_line;
        logic signed [15:0] y_min_line;
        logic signed [15:0] y_max_line;
        logic [14:0]        body_radius;
        logic [14:0]        margin_max;
        logic [14:0]        margin_full_distance;
        logic [15:0]        frame_period;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_X_MIN_LINE  = 3'd0,
        REG_X_MAX_LINE  = 3'd1,
        REG_Y_MIN_LINE  = 3'd2,
        REG_Y_MAX_LINE  = 3'd3,
        REG_BODY_RADIUS = 3'd4,
        REG_MARGIN_MAX  = 3'd5,
        REG_MARGIN_FULL = 3'd6,
        REG_FRAME_PER   = 3'd7
    } reg_idx_t;

    localparam int NUDGE_STEP = 41;
    localparam int ACC_LIMIT  = 16384;
    localparam int ACC_BITS   = 31;
    localparam int LINE_W     = 18;
    localparam int DIST_W     = 17;
    localparam int SQ_W       = 34;

    function automatic logic signed [63:0] sat_w(input logic signed [63:0] v,
                                                 input int unsigned w);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (w - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            return hi;
        end else if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

endpackage

FILE: rtl/wvl_sqrt.sv
// pipelined integer square root, one result bit per stage
module wvl_sqrt #(
    parameter int IN_W  = 34,
    parameter int PAY_W = 8,
    localparam int ROOT_W = IN_W / 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   rad,
    input  logic [PAY_W-1:0]  in_pay,
    output logic              out_valid,
    output logic [ROOT_W-1:0] root,
    output logic [PAY_W-1:0]  out_pay
);
    localparam int RW = ROOT_W + 2;

    logic [RW-1:0]     rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W];
    logic [IN_W-1:0]   rest_reg [0:ROOT_W];
    logic [PAY_W-1:0]  pay_reg  [0:ROOT_W];
    logic              vld_reg  [0:ROOT_W];

    always_comb begin
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        rest_reg[0] = rad;
        pay_reg[0]  = in_pay;
        vld_reg[0]  = in_valid;
    end

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        logic [RW+1:0]     rn;
        logic [RW+1:0]     trial;
        logic              ge;
        logic [RW+1:0]     diff;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb begin
            rn        = {rem_reg[i], rest_reg[i][IN_W-1:IN_W-2]};
            trial     = (RW+2)'({root_reg[i], 2'b01});
            ge        = (rn >= trial);
            diff      = rn - trial;
            rem_next  = ge ? diff[RW-1:0] : rn[RW-1:0];
            root_next = {root_reg[i][ROOT_W-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                rem_reg[i+1]  <= rem_next;
                root_reg[i+1] <= root_next;
                rest_reg[i+1] <= rest_reg[i] << 2;
                pay_reg[i+1]  <= pay_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign out_pay   = pay_reg[ROOT_W];

endmodule

FILE: rtl/wvl_div.sv
// pipelined saturating unsigned divider, one quotient bit per stage
module wvl_div #(
    parameter int NW    = 30,
    parameter int DW    = 15,
    parameter int QW    = 15,
    parameter int PAY_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NW-1:0]    num,
    input  logic [DW-1:0]    den,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [QW-1:0]    quo,
    output logic [PAY_W-1:0] out_pay
);
    localparam int HW = NW - QW;
    localparam int XW = HW + DW;

    logic [XW-1:0]    hi_x;
    logic [XW-1:0]    den_x;
    logic             sat;

    logic [DW-1:0]    rem_reg  [0:QW];
    logic [QW-1:0]    low_reg  [0:QW];
    logic [QW-1:0]    quo_reg  [0:QW];
    logic [DW-1:0]    den_reg  [0:QW];
    logic             sat_reg  [0:QW];
    logic [PAY_W-1:0] pay_reg  [0:QW];
    logic             vld_reg  [0:QW];

    always_comb begin
        hi_x  = XW'(num[NW-1:QW]);
        den_x = XW'(den);
        sat   = (hi_x >= den_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
        if (en) begin
            rem_reg[0] <= sat ? '0 : hi_x[DW-1:0];
            low_reg[0] <= num[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            sat_reg[0] <= sat;
            pay_reg[0] <= in_pay;
        end
    end

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic [DW:0]   tr;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;

        always_comb begin
            tr       = {rem_reg[i], low_reg[i][QW-1]};
            diff     = tr - {1'b0, den_reg[i]};
            ge       = (tr >= {1'b0, den_reg[i]});
            rem_next = ge ? diff[DW-1:0] : tr[DW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_reg[i];
            end
            if (en) begin
                rem_reg[i+1] <= rem_next;
                low_reg[i+1] <= low_reg[i] << 1;
                quo_reg[i+1] <= {quo_reg[i][QW-2:0], ge};
                den_reg[i+1] <= den_reg[i];
                sat_reg[i+1] <= sat_reg[i];
                pay_reg[i+1] <= pay_reg[i];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo       = sat_reg[QW] ? '1 : quo_reg[QW];
    assign out_pay   = pay_reg[QW];

endmodule

FILE: rtl/wvl_limit.sv
// one wall check: deceleration v*v/gap, then velocity clamp toward the pushout limit
module wvl_limit #(
    parameter int VW    = 17,
    parameter int GW    = 20,
    parameter bit DIR   = 1'b0,
    parameter int PAY_W = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [VW-1:0] v_in,
    input  logic signed [GW-1:0] gap,
    input  logic                 bypass,
    input  logic [15:0]          fp,
    input  logic [PAY_W-1:0]     in_pay,
    output logic                 out_valid,
    output logic signed [VW-1:0] v_out,
    output logic [PAY_W-1:0]     out_pay
);
    import wvl_pkg::*;

    localparam int NW = (2 * VW > 32) ? 2 * VW : 32;
    localparam int TW = ((VW > 32) ? VW : 32) + 2;
    localparam int DPW = 1 + VW + PAY_W;

    logic [VW-1:0]       av;
    logic [GW-1:0]       ag;
    logic                active;

    logic                a_vld_reg;
    logic [2*VW-1:0]     sq_reg;
    logic [GW-1:0]       ag_reg;
    logic                act_reg;
    logic signed [VW-1:0] v_reg;
    logic [PAY_W-1:0]    pay_reg;

    logic                d_vld;
    logic [ACC_BITS-1:0] acc;
    logic [DPW-1:0]      d_pay;

    logic                m_vld_reg;
    logic [ACC_BITS+15:0] mul_reg;
    logic                big_reg;
    logic [DPW-1:0]      m_pay_reg;

    logic signed [VW-1:0] vm;
    logic signed [TW-1:0] dv_s;
    logic signed [TW-1:0] t;
    logic signed [TW-1:0] pp;
    logic signed [TW-1:0] clamp;
    logic signed [VW-1:0] v_next;

    logic                o_vld_reg;
    logic signed [VW-1:0] o_v_reg;
    logic [PAY_W-1:0]    o_pay_reg;

    always_comb begin
        av     = v_in[VW-1] ? VW'(-v_in) : VW'(v_in);
        ag     = gap[GW-1] ? GW'(-gap) : GW'(gap);
        active = !bypass && (DIR ? (v_in > 0) : (v_in < 0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (en) begin
            a_vld_reg <= in_valid;
        end
        if (en) begin
            sq_reg  <= av * av;
            ag_reg  <= ag;
            act_reg <= active;
            v_reg   <= v_in;
            pay_reg <= in_pay;
        end
    end

    wvl_div #(
        .NW(NW), .DW(GW), .QW(ACC_BITS), .PAY_W(DPW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_vld_reg),
        .num      (NW'(sq_reg)),
        .den      (ag_reg),
        .in_pay   ({act_reg, v_reg, pay_reg}),
        .out_valid(d_vld),
        .quo      (acc),
        .out_pay  (d_pay)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (en) begin
            m_vld_reg <= d_vld;
        end
        if (en) begin
            mul_reg   <= acc * fp;
            big_reg   <= (acc > ACC_BITS'(ACC_LIMIT));
            m_pay_reg <= d_pay;
        end
    end

    always_comb begin
        vm    = $signed(m_pay_reg[PAY_W +: VW]);
        dv_s  = $signed(TW'(mul_reg[ACC_BITS+15:16]));
        pp    = $signed(TW'(fp[15:2]));
        if (DIR) begin
            t     = TW'(vm) - dv_s;
            clamp = (t > -pp) ? t : -pp;
        end else begin
            t     = TW'(vm) + dv_s;
            clamp = (t < pp) ? t : pp;
        end
        v_next = (m_pay_reg[DPW-1] && big_reg) ? VW'(clamp) : vm;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= m_vld_reg;
        end
        if (en) begin
            o_v_reg   <= v_next;
            o_pay_reg <= m_pay_reg[PAY_W-1:0];
        end
    end

    assign out_valid = o_vld_reg;
    assign v_out     = o_v_reg;
    assign out_pay   = o_pay_reg;

endmodule

FILE: rtl/wvl_front.sv
// front end: distance, margin, margin lines, nudge check and wall gaps
module wvl_front #(
    parameter int W  = 16,
    parameter int GW = 20,
    localparam int EW = 4 * W + 1 + 4 * GW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  wvl_pkg::cfg_t cfg,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [6*W-1:0] in_data,
    input  logic          q_full,
    output logic          q_push,
    output logic [EW-1:0] q_entry
);
    import wvl_pkg::*;

    localparam int PW = 4 * W + 1;
    localparam int CW = ((W > 17) ? W : 17) + 1;
    localparam int LW = GW - 1;

    logic                 front_en;

    logic                 s0_vld_reg;
    logic [6*W-1:0]       s0_dat_reg;
    logic signed [W-1:0]  dxs, dys, pxs, pys;
    logic signed [W:0]    ddx, ddy;
    logic [W:0]           magx, magy;
    logic [32:0]          mx, my;
    logic [15:0]          ex, ey;
    logic signed [CW-1:0] xlo_b, xhi_b, ylo_b, yhi_b, dxe, dye;
    logic                 dest_in;

    logic                 s1_vld_reg;
    logic [31:0]          sqx_reg, sqy_reg;
    logic [PW-1:0]        s1_pay_reg;

    logic                 sq_vld;
    logic [DIST_W-1:0]    dest_dist;
    logic [PW-1:0]        sq_pay;

    logic                 s2_vld_reg;
    logic [29:0]          prod_reg;
    logic [PW:0]          s2_pay_reg;

    logic                 dv_vld;
    logic [14:0]          quo;
    logic [PW:0]          dv_pay;

    logic [14:0]          margin;
    logic signed [LINE_W-1:0] br_s, mg_s, ylo, yhi, xlo, xhi;

    logic                 e_vld_reg;
    logic signed [LINE_W-1:0] ylo_reg, yhi_reg, xlo_reg, xhi_reg;
    logic [4*W-1:0]       e_pay_reg;

    logic signed [W-1:0]  ex_x, ex_y;
    logic signed [LW-1:0] xe, ye, nx, ny;
    logic                 nudged;
    logic signed [GW-1:0] gylo, gyhi, gxlo, gxhi;
    logic [W-1:0]         x_o, y_o;

    assign front_en = !(e_vld_reg && q_full);
    assign in_ready = front_en;
    assign q_push   = e_vld_reg && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (front_en) begin
            s0_vld_reg <= in_valid;
        end
        if (front_en) begin
            s0_dat_reg <= in_data;
        end
    end

    always_comb begin
        dxs   = $signed(s0_dat_reg[W-1:0]);
        dys   = $signed(s0_dat_reg[2*W-1:W]);
        pxs   = $signed(s0_dat_reg[3*W-1:2*W]);
        pys   = $signed(s0_dat_reg[4*W-1:3*W]);
        ddx   = (W+1)'(dxs) - (W+1)'(pxs);
        ddy   = (W+1)'(dys) - (W+1)'(pys);
        magx  = ddx[W] ? (W+1)'(-ddx) : (W+1)'(ddx);
        magy  = ddy[W] ? (W+1)'(-ddy) : (W+1)'(ddy);
        mx    = 33'(magx);
        my    = 33'(magy);
        ex    = (mx > 33'd65535) ? 16'hFFFF : mx[15:0];
        ey    = (my > 33'd65535) ? 16'hFFFF : my[15:0];
        xlo_b = CW'(cfg.x_min_line) - CW'($signed({1'b0, cfg.body_radius}));
        xhi_b = CW'(cfg.x_max_line) + CW'($signed({1'b0, cfg.body_radius}));
        ylo_b = CW'(cfg.y_min_line) + CW'($signed({1'b0, cfg.body_radius}));
        yhi_b = CW'(cfg.y_max_line) - CW'($signed({1'b0, cfg.body_radius}));
        dxe   = CW'(dxs);
        dye   = CW'(dys);
        dest_in = (dxe < xhi_b) && (dxe > xlo_b) && (dye < yhi_b) && (dye > ylo_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (front_en) begin
            s1_vld_reg <= s0_vld_reg;
        end
        if (front_en) begin
            sqx_reg    <= ex * ex;
            sqy_reg    <= ey * ey;
            s1_pay_reg <= {dest_in, s0_dat_reg[6*W-1:2*W]};
        end
    end

    wvl_sqrt #(
        .IN_W(SQ_W), .PAY_W(PW)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (front_en),
        .in_valid (s1_vld_reg),
        .rad      (SQ_W'(sqx_reg) + SQ_W'(sqy_reg)),
        .in_pay   (s1_pay_reg),
        .out_valid(sq_vld),
        .root     (dest_dist),
        .out_pay  (sq_pay)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (front_en) begin
            s2_vld_reg <= sq_vld;
        end
        if (front_en) begin
            prod_reg   <= cfg.margin_max * dest_dist[14:0];
            s2_pay_reg <= {(cfg.margin_full_distance == '0) ||
                           (dest_dist > DIST_W'(cfg.margin_full_distance)), sq_pay};
        end
    end

    wvl_div #(
        .NW(30), .DW(15), .QW(15), .PAY_W(PW + 1)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (front_en),
        .in_valid (s2_vld_reg),
        .num      (prod_reg),
        .den      (cfg.margin_full_distance),
        .in_pay   (s2_pay_reg),
        .out_valid(dv_vld),
        .quo      (quo),
        .out_pay  (dv_pay)
    );

    always_comb begin
        if (dv_pay[PW-1]) begin
            margin = '0;
        end else if (dv_pay[PW]) begin
            margin = cfg.margin_max;
        end else begin
            margin = quo;
        end
        br_s = $signed(LINE_W'(cfg.body_radius));
        mg_s = $signed(LINE_W'(margin));
        ylo  = LINE_W'(cfg.y_min_line) + br_s + mg_s;
        yhi  = LINE_W'(cfg.y_max_line) - br_s - mg_s;
        xlo  = LINE_W'(cfg.x_min_line) + br_s + mg_s;
        xhi  = LINE_W'(cfg.x_max_line) - br_s - mg_s;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_vld_reg <= 1'b0;
        end else if (front_en) begin
            e_vld_reg <= dv_vld;
        end
        if (front_en) begin
            ylo_reg   <= ylo;
            yhi_reg   <= yhi;
            xlo_reg   <= xlo;
            xhi_reg   <= xhi;
            e_pay_reg <= dv_pay[4*W-1:0];
        end
    end

    always_comb begin
        ex_x   = $signed(e_pay_reg[W-1:0]);
        ex_y   = $signed(e_pay_reg[2*W-1:W]);
        xe     = LW'(ex_x);
        ye     = LW'(ex_y);
        nx     = xe;
        ny     = ye;
        nudged = 1'b1;
        if (ye == LW'(ylo_reg)) begin
            ny = ye + LW'(NUDGE_STEP);
        end else if (ye == LW'(yhi_reg)) begin
            ny = ye - LW'(NUDGE_STEP);
        end else if (xe == LW'(xlo_reg)) begin
            nx = xe + LW'(NUDGE_STEP);
        end else if (xe == LW'(xhi_reg)) begin
            nx = xe - LW'(NUDGE_STEP);
        end else begin
            nudged = 1'b0;
        end
        x_o  = W'(sat_w(64'(nx), W));
        y_o  = W'(sat_w(64'(ny), W));
        gylo = GW'(ex_y) - GW'(ylo_reg);
        gyhi = GW'(yhi_reg) - GW'(ex_y);
        gxlo = GW'(ex_x) - GW'(xlo_reg);
        gxhi = GW'(xhi_reg) - GW'(ex_x);
    end

    assign q_entry = {gxhi, gxlo, gyhi, gylo, nudged, e_pay_reg[4*W-1:2*W], y_o, x_o};

endmodule

FILE: rtl/wvl_queue.sv
// short item queue between front and back ends
module wvl_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic [DW-1:0] din,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output logic [DW-1:0] dout
);
    localparam int AW = $clog2(DEPTH);

    logic [DW-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
        if (push) begin
            mem_reg[wp_reg] <= din;
        end
    end

endmodule

FILE: rtl/wvl_back.sv
// back end: the four wall limits and the output register
module wvl_back #(
    parameter int W  = 16,
    parameter int GW = 20,
    localparam int EW = 4 * W + 1 + 4 * GW
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [15:0]    fp,
    input  logic           q_empty,
    output logic           q_pop,
    input  logic [EW-1:0]  q_entry,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [4*W-1:0] m_data,
    output logic           m_nudged
);
    import wvl_pkg::*;

    localparam int VW = ((W > 15) ? W : 15) + 1;

    logic                 back_en;
    logic                 b0_vld_reg;
    logic [EW-1:0]        b0_ent_reg;

    logic [W-1:0]         x_b, y_b;
    logic signed [W-1:0]  vx_b, vy_b;
    logic                 nud_b;
    logic signed [GW-1:0] gylo, gyhi, gxlo, gxhi;

    logic                 y1_vld, y2_vld, x1_vld, x2_vld;
    logic signed [VW-1:0] vy1, vy2, vx1, vx2;
    logic [GW+2*W:0]      y1_pay;
    logic [2*W-1:0]       y2_pay;
    logic [GW:0]          x1_pay;
    logic                 x2_pay;

    logic                 out_vld_reg;
    logic [4*W-1:0]       out_dat_reg;
    logic                 out_nud_reg;

    assign back_en = !out_vld_reg || m_ready;
    assign q_pop   = back_en && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b0_vld_reg <= 1'b0;
        end else if (back_en) begin
            b0_vld_reg <= !q_empty;
        end
        if (back_en) begin
            b0_ent_reg <= q_entry;
        end
    end

    always_comb begin
        x_b   = b0_ent_reg[W-1:0];
        y_b   = b0_ent_reg[2*W-1:W];
        vx_b  = $signed(b0_ent_reg[3*W-1:2*W]);
        vy_b  = $signed(b0_ent_reg[4*W-1:3*W]);
        nud_b = b0_ent_reg[4*W];
        gylo  = $signed(b0_ent_reg[4*W+1 +: GW]);
        gyhi  = $signed(b0_ent_reg[4*W+1+GW +: GW]);
        gxlo  = $signed(b0_ent_reg[4*W+1+2*GW +: GW]);
        gxhi  = $signed(b0_ent_reg[4*W+1+3*GW +: GW]);
    end

    wvl_limit #(.VW(VW), .GW(GW), .DIR(1'b0), .PAY_W(GW + 2 * W + 1)) u_ylo (
        .aclk(aclk), .aresetn(aresetn), .en(back_en), .in_valid(b0_vld_reg),
        .v_in(VW'(vy_b)), .gap(gylo), .bypass(nud_b), .fp(fp),
        .in_pay({nud_b, gyhi, y_b, x_b}),
        .out_valid(y1_vld), .v_out(vy1), .out_pay(y1_pay)
    );

    wvl_limit #(.VW(VW), .GW(GW), .DIR(1'b1), .PAY_W(2 * W)) u_yhi (
        .aclk(aclk), .aresetn(aresetn), .en(back_en), .in_valid(y1_vld),
        .v_in(vy1), .gap($signed(y1_pay[2*W +: GW])), .bypass(y1_pay[GW+2*W]),
        .fp(fp), .in_pay(y1_pay[2*W-1:0]),
        .out_valid(y2_vld), .v_out(vy2), .out_pay(y2_pay)
    );

    wvl_limit #(.VW(VW), .GW(GW), .DIR(1'b0), .PAY_W(GW + 1)) u_xlo (
        .aclk(aclk), .aresetn(aresetn), .en(back_en), .in_valid(b0_vld_reg),
        .v_in(VW'(vx_b)), .gap(gxlo), .bypass(nud_b), .fp(fp),
        .in_pay({nud_b, gxhi}),
        .out_valid(x1_vld), .v_out(vx1), .out_pay(x1_pay)
    );

    wvl_limit #(.VW(VW), .GW(GW), .DIR(1'b1), .PAY_W(1)) u_xhi (
        .aclk(aclk), .aresetn(aresetn), .en(back_en), .in_valid(x1_vld),
        .v_in(vx1), .gap($signed(x1_pay[GW-1:0])), .bypass(x1_pay[GW]),
        .fp(fp), .in_pay(x1_pay[GW]),
        .out_valid(x2_vld), .v_out(vx2), .out_pay(x2_pay)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (back_en) begin
            out_vld_reg <= y2_vld && x2_vld;
        end
        if (back_en) begin
            out_dat_reg <= {W'(sat_w(64'(vy2), W)), W'(sat_w(64'(vx2), W)), y2_pay};
            out_nud_reg <= x2_pay;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_data   = out_dat_reg;
    assign m_nudged = out_nud_reg;

endmodule

FILE: rtl/wall_velocity_limiter.sv
// top level of the wall velocity limiter
//
// usage:
// - s_ channel: one item per handshake, a destination and a predicted step
//   (position and velocity); m_ channel: the nudged position and limited
//   velocity, with the nudge flag in m_tuser
// - cfg_we/cfg_index/cfg_wdata write the arena lines, robot radius, margin
//   settings and frame period; write only while no item is in flight
// - throughput: one item per cycle while the output is not stalled, every
//   stage of the root and of the dividers being its own pipeline stage
// - latency from accept to m_tvalid with no stall comes mostly from the
//   bit-per-stage root and dividers of the front end and the back end
// - a four-entry queue sits between the front end (distance, margin, nudge)
//   and the back end (four wall limits)
// - when m_tready is low the back end holds; the queue then fills and
//   s_tready drops once the front end has an item it cannot hand over
// - reset clears all valid flags and the queue and loads the register
//   defaults; the block takes items in the first cycle after reset
module wall_velocity_limiter #(
    parameter int COORD_WIDTH = 16,
    localparam int IN_DW  = ((6 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_DW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // dest_x, dest_y, step_x, step_y, step_vx, step_vy
    input  logic [IN_DW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_x, out_y, out_vx, out_vy
    output logic [OUT_DW-1:0] m_tdata,
    // nudged
    output logic              m_tuser,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wdata
);
    import wvl_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int GW = ((W > LINE_W) ? W : LINE_W) + 2;
    localparam int EW = 4 * W + 1 + 4 * GW;

    cfg_t           cfg_reg;
    logic           q_full, q_push, q_empty, q_pop;
    logic [EW-1:0]  q_in, q_out;
    logic [4*W-1:0] m_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.x_min_line           <= -16'sd5612;
            cfg_reg.x_max_line           <= 16'sd5612;
            cfg_reg.y_min_line           <= -16'sd3123;
            cfg_reg.y_max_line           <= 16'sd3123;
            cfg_reg.body_radius          <= 15'd369;
            cfg_reg.margin_max           <= 15'd205;
            cfg_reg.margin_full_distance <= 15'd2048;
            cfg_reg.frame_period         <= 16'd1092;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_X_MIN_LINE:  cfg_reg.x_min_line           <= $signed(cfg_wdata);
                REG_X_MAX_LINE:  cfg_reg.x_max_line           <= $signed(cfg_wdata);
                REG_Y_MIN_LINE:  cfg_reg.y_min_line           <= $signed(cfg_wdata);
                REG_Y_MAX_LINE:  cfg_reg.y_max_line           <= $signed(cfg_wdata);
                REG_BODY_RADIUS: cfg_reg.body_radius          <= cfg_wdata[14:0];
                REG_MARGIN_MAX:  cfg_reg.margin_max           <= cfg_wdata[14:0];
                REG_MARGIN_FULL: cfg_reg.margin_full_distance <= cfg_wdata[14:0];
                REG_FRAME_PER:   cfg_reg.frame_period         <= cfg_wdata;
                default: ;
            endcase
        end
    end

    wvl_front #(.W(W), .GW(GW)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_data (s_tdata[6*W-1:0]),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_entry (q_in)
    );

    wvl_queue #(.DW(EW), .DEPTH(4)) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .din    (q_in),
        .full   (q_full),
        .pop    (q_pop),
        .empty  (q_empty),
        .dout   (q_out)
    );

    wvl_back #(.W(W), .GW(GW)) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fp      (cfg_reg.frame_period),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_entry (q_out),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_data  (m_data),
        .m_nudged(m_tuser)
    );

    assign m_tdata = OUT_DW'(m_data);

endmodule

FILE: rtl/wvl_checker.sv
// port checker of the wall velocity limiter and its bind
module wvl_checker #(
    parameter int COORD_WIDTH = 16,
    localparam int OUT_DW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_DW-1:0] m_tdata,
    input logic              m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind wall_velocity_limiter wvl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_wvl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
